### design/psd3_pkg.sv
// ============================================================================
// psd3_pkg -- point to segment distance, shared types and constants
// Field widths, internal datapath widths, region codes and pipeline depth.
// ============================================================================
package psd3_pkg;

    localparam int CW     = 32;          // coordinate width
    localparam int DW     = CW + 1;      // coordinate difference
    localparam int PW     = 2 * DW;      // product of two differences
    localparam int SW     = PW + 2;      // sum of three products
    localparam int CRW    = PW + 1;      // cross product component
    localparam int MW     = PW;          // cross component magnitude
    localparam int HW     = MW / 2;      // half of a magnitude
    localparam int KW     = 2 * MW;      // square of a magnitude
    localparam int NW     = KW + 2;      // sum of three squares (dividend)
    localparam int QW     = SW;          // quotient / squared distance
    localparam int RTW    = QW / 2;      // square root
    localparam int RMW    = RTW + 3;     // square root remainder
    localparam int DIST_W = 33;          // result width
    localparam int FRONT  = 7;           // stages before the divider
    localparam int LATENCY = FRONT + QW + RTW + 1;

    typedef enum logic [1:0] {
        REG_PERP  = 2'd0,
        REG_START = 2'd1,
        REG_END   = 2'd2
    } region_t;

    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic signed [CW-1:0] point_z;
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] start_z;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
        logic signed [CW-1:0] end_z;
    } query_t;

    typedef struct packed {
        logic [DIST_W-1:0] dist_res;
        region_t           region;
    } result_t;

endpackage

### design/point_segment_distance_3d.sv
// ============================================================================
// point_segment_distance_3d -- Euclidean distance from a point to a 3D segment
// Fully pipelined: differences, dot/cross products, a bit-per-stage divider
// and a bit-per-stage square root, with valid bits riding along the data.
// ============================================================================
// Throughput: one beat per clock; busy is never raised since every stage
// advances each cycle and the receiver takes results without backpressure.
// The depth is set by the 68-stage divider and 34-stage square root.
// Reset clears only the valid bits; payload registers are not reset.
module point_segment_distance_3d
    import psd3_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  query_t  query,
    output logic    done,
    output result_t result
);

    // ------------------------------------------------------------------
    // Stage 1: vectors a0 = P-S, a1 = P-E, ev = E-S (33-bit signed)
    // ------------------------------------------------------------------
    logic                 v1_reg;
    logic signed [DW-1:0] a0_reg [3];
    logic signed [DW-1:0] a1_reg [3];
    logic signed [DW-1:0] ev_reg [3];
    logic signed [DW-1:0] a0_next [3];
    logic signed [DW-1:0] a1_next [3];
    logic signed [DW-1:0] ev_next [3];
    logic signed [CW-1:0] pc [3];
    logic signed [CW-1:0] sc [3];
    logic signed [CW-1:0] ec [3];

    assign busy = 1'b0;

    assign pc[0] = query.point_x;
    assign pc[1] = query.point_y;
    assign pc[2] = query.point_z;
    assign sc[0] = query.start_x;
    assign sc[1] = query.start_y;
    assign sc[2] = query.start_z;
    assign ec[0] = query.end_x;
    assign ec[1] = query.end_y;
    assign ec[2] = query.end_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            a0_next[k] = DW'(pc[k]) - DW'(sc[k]);
            a1_next[k] = DW'(pc[k]) - DW'(ec[k]);
            ev_next[k] = DW'(ec[k]) - DW'(sc[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        a0_reg <= a0_next;
        a1_reg <= a1_next;
        ev_reg <= ev_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: all 33x33 products, each in its own register
    // ------------------------------------------------------------------
    logic                 v2_reg;
    logic signed [PW-1:0] md0_reg [3];   // a0.ev terms
    logic signed [PW-1:0] md1_reg [3];   // a1.ev terms
    logic signed [PW-1:0] mq0_reg [3];   // a0.a0 terms
    logic signed [PW-1:0] mq1_reg [3];   // a1.a1 terms
    logic signed [PW-1:0] mee_reg [3];   // ev.ev terms
    logic signed [PW-1:0] mcp_reg [3];   // cross, positive term
    logic signed [PW-1:0] mcn_reg [3];   // cross, negative term

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            md0_reg[k] <= PW'(a0_reg[k]) * PW'(ev_reg[k]);
            md1_reg[k] <= PW'(a1_reg[k]) * PW'(ev_reg[k]);
            mq0_reg[k] <= PW'(a0_reg[k]) * PW'(a0_reg[k]);
            mq1_reg[k] <= PW'(a1_reg[k]) * PW'(a1_reg[k]);
            mee_reg[k] <= PW'(ev_reg[k]) * PW'(ev_reg[k]);
        end
        mcp_reg[0] <= PW'(a0_reg[1]) * PW'(ev_reg[2]);
        mcn_reg[0] <= PW'(a0_reg[2]) * PW'(ev_reg[1]);
        mcp_reg[1] <= PW'(a0_reg[2]) * PW'(ev_reg[0]);
        mcn_reg[1] <= PW'(a0_reg[0]) * PW'(ev_reg[2]);
        mcp_reg[2] <= PW'(a0_reg[0]) * PW'(ev_reg[1]);
        mcn_reg[2] <= PW'(a0_reg[1]) * PW'(ev_reg[0]);
    end

    // ------------------------------------------------------------------
    // Stage 3: dot product sums and cross product components
    // ------------------------------------------------------------------
    logic                  v3_reg;
    logic signed [SW-1:0]  d0_reg;
    logic signed [SW-1:0]  d1_reg;
    logic signed [SW-1:0]  sq0_reg;
    logic signed [SW-1:0]  sq1_reg;
    logic signed [SW-1:0]  ee3_reg;
    logic signed [CRW-1:0] cr_reg [3];

    always_ff @(posedge clk)
    begin
        d0_reg  <= SW'(md0_reg[0]) + SW'(md0_reg[1]) + SW'(md0_reg[2]);
        d1_reg  <= SW'(md1_reg[0]) + SW'(md1_reg[1]) + SW'(md1_reg[2]);
        sq0_reg <= SW'(mq0_reg[0]) + SW'(mq0_reg[1]) + SW'(mq0_reg[2]);
        sq1_reg <= SW'(mq1_reg[0]) + SW'(mq1_reg[1]) + SW'(mq1_reg[2]);
        ee3_reg <= SW'(mee_reg[0]) + SW'(mee_reg[1]) + SW'(mee_reg[2]);
        for (int k = 0; k < 3; k++)
        begin
            cr_reg[k] <= CRW'(mcp_reg[k]) - CRW'(mcn_reg[k]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: region decision, endpoint distance select, |cross|
    // ------------------------------------------------------------------
    logic             v4_reg;
    region_t          rg4_reg;
    logic [SW-1:0]    sel4_reg;
    logic [SW-1:0]    ee4_reg;
    logic [MW-1:0]    mag4_reg [3];
    region_t          rg4_next;
    logic [SW-1:0]    sel4_next;
    logic             ge0;
    logic             ge1;
    logic             le0;
    logic             le1;
    logic [CRW-1:0]   cr_abs [3];

    always_comb
    begin
        ge0 = !d0_reg[SW-1];
        ge1 = !d1_reg[SW-1];
        le0 = d0_reg[SW-1] || (d0_reg == '0);
        le1 = d1_reg[SW-1] || (d1_reg == '0);
        // zero-length edge lands here: both dots are zero
        priority if (ge0 && ge1)
        begin
            rg4_next  = REG_END;
            sel4_next = sq1_reg;
        end
        else if (le0 && le1)
        begin
            rg4_next  = REG_START;
            sel4_next = sq0_reg;
        end
        else
        begin
            rg4_next  = REG_PERP;
            sel4_next = sq0_reg;
        end
        for (int k = 0; k < 3; k++)
        begin
            cr_abs[k] = cr_reg[k][CRW-1] ? CRW'(-cr_reg[k]) : CRW'(cr_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        rg4_reg  <= rg4_next;
        sel4_reg <= sel4_next;
        ee4_reg  <= ee3_reg;
        for (int k = 0; k < 3; k++)
        begin
            mag4_reg[k] <= cr_abs[k][MW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: |cross|^2 split into half-width partial products
    // ------------------------------------------------------------------
    logic             v5_reg;
    region_t          rg5_reg;
    logic [SW-1:0]    sel5_reg;
    logic [SW-1:0]    ee5_reg;
    logic [MW-1:0]    hh_reg [3];
    logic [MW-1:0]    hl_reg [3];
    logic [MW-1:0]    ll_reg [3];

    always_ff @(posedge clk)
    begin
        rg5_reg  <= rg4_reg;
        sel5_reg <= sel4_reg;
        ee5_reg  <= ee4_reg;
        for (int k = 0; k < 3; k++)
        begin
            hh_reg[k] <= MW'(mag4_reg[k][MW-1:HW]) * MW'(mag4_reg[k][MW-1:HW]);
            hl_reg[k] <= MW'(mag4_reg[k][MW-1:HW]) * MW'(mag4_reg[k][HW-1:0]);
            ll_reg[k] <= MW'(mag4_reg[k][HW-1:0]) * MW'(mag4_reg[k][HW-1:0]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: recombine the squares
    // ------------------------------------------------------------------
    logic             v6_reg;
    region_t          rg6_reg;
    logic [SW-1:0]    sel6_reg;
    logic [SW-1:0]    ee6_reg;
    logic [KW-1:0]    csq_reg [3];

    always_ff @(posedge clk)
    begin
        rg6_reg  <= rg5_reg;
        sel6_reg <= sel5_reg;
        ee6_reg  <= ee5_reg;
        for (int k = 0; k < 3; k++)
        begin
            csq_reg[k] <= (KW'(hh_reg[k]) << (2 * HW))
                        + (KW'(hl_reg[k]) << (HW + 1))
                        + KW'(ll_reg[k]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: |cross|^2 sum, divider operands. Endpoint cases divide by one.
    // ------------------------------------------------------------------
    logic [NW-1:0]    cc_sum;
    logic [NW-1:0]    num_next;
    logic [QW-1:0]    den_next;

    logic [QW:0]      dv_v_reg;
    logic [QW-1:0]    dv_r_reg [QW+1];
    logic [QW-1:0]    dv_n_reg [QW+1];
    logic [QW-1:0]    dv_q_reg [QW+1];
    logic [QW-1:0]    dv_d_reg [QW+1];
    region_t          dv_g_reg [QW+1];

    always_comb
    begin
        cc_sum = NW'(csq_reg[0]) + NW'(csq_reg[1]) + NW'(csq_reg[2]);
        if (rg6_reg == REG_PERP)
        begin
            // zero edge guard: squared distance taken as zero
            num_next = (ee6_reg == '0) ? '0 : cc_sum;
            den_next = (ee6_reg == '0) ? QW'(1) : ee6_reg;
        end
        else
        begin
            num_next = NW'(sel6_reg);
            den_next = QW'(1);
        end
    end

    // quotient fits QW bits, so the top dividend bits seed the remainder
    always_ff @(posedge clk)
    begin
        dv_r_reg[0] <= QW'(num_next[NW-1:QW]);
        dv_n_reg[0] <= num_next[QW-1:0];
        dv_q_reg[0] <= '0;
        dv_d_reg[0] <= den_next;
        dv_g_reg[0] <= rg6_reg;
    end

    // ------------------------------------------------------------------
    // Divider: restoring, one quotient bit per stage
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < QW; gi++)
        begin : g_div
            logic [QW:0] trial;
            logic [QW:0] diff;
            logic        take;

            assign trial = {dv_r_reg[gi], dv_n_reg[gi][QW-1]};
            assign diff  = trial - {1'b0, dv_d_reg[gi]};
            assign take  = (trial >= {1'b0, dv_d_reg[gi]});

            always_ff @(posedge clk)
            begin
                dv_r_reg[gi+1] <= take ? diff[QW-1:0] : trial[QW-1:0];
                dv_n_reg[gi+1] <= {dv_n_reg[gi][QW-2:0], 1'b0};
                dv_q_reg[gi+1] <= {dv_q_reg[gi][QW-2:0], take};
                dv_d_reg[gi+1] <= dv_d_reg[gi];
                dv_g_reg[gi+1] <= dv_g_reg[gi];
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Square root: digit by digit, one root bit per stage
    // ------------------------------------------------------------------
    logic [RTW-1:0]   sq_v_reg;
    logic [QW-1:0]    sq_x_reg  [RTW];
    logic [RMW-1:0]   sq_rm_reg [RTW];
    logic [RTW-1:0]   sq_rt_reg [RTW];
    region_t          sq_g_reg  [RTW];

    generate
        for (gi = 0; gi < RTW; gi++)
        begin : g_sqrt
            logic [QW-1:0]  x_in;
            logic [RMW-1:0] rm_in;
            logic [RTW-1:0] rt_in;
            region_t        g_in;
            logic [RMW-1:0] part;
            logic [RMW-1:0] trial;
            logic           take;

            if (gi == 0)
            begin : g_first
                assign x_in  = dv_q_reg[QW];
                assign rm_in = '0;
                assign rt_in = '0;
                assign g_in  = dv_g_reg[QW];
            end
            else
            begin : g_rest
                assign x_in  = sq_x_reg[gi-1];
                assign rm_in = sq_rm_reg[gi-1];
                assign rt_in = sq_rt_reg[gi-1];
                assign g_in  = sq_g_reg[gi-1];
            end

            assign part  = {rm_in[RMW-3:0], x_in[QW-1:QW-2]};
            assign trial = RMW'({rt_in, 2'b01});
            assign take  = (part >= trial);

            always_ff @(posedge clk)
            begin
                sq_x_reg[gi]  <= {x_in[QW-3:0], 2'b00};
                sq_rm_reg[gi] <= take ? (part - trial) : part;
                sq_rt_reg[gi] <= {rt_in[RTW-2:0], take};
                sq_g_reg[gi]  <= g_in;
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Output register with saturation
    // ------------------------------------------------------------------
    logic    done_reg;
    result_t result_reg;
    result_t result_next;
    logic [RTW-1:0] root_fin;

    always_comb
    begin
        root_fin             = sq_rt_reg[RTW-1];
        result_next.region   = sq_g_reg[RTW-1];
        result_next.dist_res = ((root_fin >> DIST_W) != '0) ? '1
                             : root_fin[DIST_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // valid bits, the only reset state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            dv_v_reg <= '0;
            sq_v_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            dv_v_reg <= {dv_v_reg[QW-1:0], v6_reg};
            sq_v_reg <= {sq_v_reg[RTW-2:0], dv_v_reg[QW]};
            done_reg <= sq_v_reg[RTW-1];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### design/psd3_checker.sv
// ============================================================================
// psd3_checker -- port-level checks for point_segment_distance_3d
// Fixed latency between accepted beats and result strobes, legal region, zero edge on the endpoint branch.
// ============================================================================
module psd3_checker
    import psd3_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input query_t  query,
    input logic    done,
    input result_t result
);

    // every accepted beat yields a matching result strobe
    a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("missing result strobe");

    // no result without a matching accepted beat
    a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("spurious result strobe");

    a_region: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.region != 2'd3))
        else $error("illegal region code");

    // a zero-length segment reports the second endpoint
    a_zero_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && query.start_x == query.end_x
         && query.start_y == query.end_y && query.start_z == query.end_z)
        |-> ##LATENCY (result.region == REG_END))
        else $error("zero edge not on endpoint branch");

endmodule

bind point_segment_distance_3d psd3_checker u_psd3_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .query  (query),
    .done   (done),
    .result (result)
);

### bench/tb_top.sv
// ============================================================================
// tb_top -- point to segment distance bench
// Drives query beats through the pipelined distance block, predicts each
// distance and region with wide exact arithmetic, and checks every done beat.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import psd3_pkg::*;

    localparam int WD_LIMIT = 4 * LATENCY + 400;   // cycles with no beat at all
    localparam int WIDE = 256;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] ONE  = 32'sd65536;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    query_t  query;
    logic    done;
    result_t result;

    result_t expected_dist[$];
    int      fails = 0;
    int      idle_cycles = 0;
    int      burst_left;

    point_segment_distance_3d DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .query  (query),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Exact distance: dot products pick the branch, then floor sqrt of the
    // squared distance (floor of |cross|^2/|edge|^2 for the interior case).
    function automatic result_t predict_distance(query_t q);
        logic signed [WIDE-1:0] a0[3], a1[3], ev[3], cr[3];
        logic signed [WIDE-1:0] d0, d1, sq, cc, ee, root, trial;
        result_t r;
        a0[0] = q.point_x - q.start_x;
        a0[1] = q.point_y - q.start_y;
        a0[2] = q.point_z - q.start_z;
        a1[0] = q.point_x - q.end_x;
        a1[1] = q.point_y - q.end_y;
        a1[2] = q.point_z - q.end_z;
        ev[0] = q.end_x - q.start_x;
        ev[1] = q.end_y - q.start_y;
        ev[2] = q.end_z - q.start_z;
        d0 = a0[0] * ev[0] + a0[1] * ev[1] + a0[2] * ev[2];
        d1 = a1[0] * ev[0] + a1[1] * ev[1] + a1[2] * ev[2];
        if (d0 >= 0 && d1 >= 0)
        begin
            r.region = REG_END;
            sq = a1[0] * a1[0] + a1[1] * a1[1] + a1[2] * a1[2];
        end
        else if (d0 <= 0 && d1 <= 0)
        begin
            r.region = REG_START;
            sq = a0[0] * a0[0] + a0[1] * a0[1] + a0[2] * a0[2];
        end
        else
        begin
            r.region = REG_PERP;
            cr[0] = a0[1] * ev[2] - a0[2] * ev[1];
            cr[1] = a0[2] * ev[0] - a0[0] * ev[2];
            cr[2] = a0[0] * ev[1] - a0[1] * ev[0];
            cc = cr[0] * cr[0] + cr[1] * cr[1] + cr[2] * cr[2];
            ee = ev[0] * ev[0] + ev[1] * ev[1] + ev[2] * ev[2];
            sq = (ee == 0) ? '0 : cc / ee;
        end
        // bit-serial floor square root; sq < 2^140 so the root fits 72 bits
        root = '0;
        for (int i = 71; i >= 0; i--)
        begin
            trial = root | (WIDE'(1) << i);
            if (trial * trial <= sq)
                root = trial;
        end
        r.dist_res = (root > $signed({1'b0, DIST_MAX})) ? DIST_MAX : root[DIST_W-1:0];
        return r;
    endfunction

    function automatic query_t mk_query(
        logic signed [CW-1:0] px, py, pz, sx, sy, sz, ex, ey, ez);
        query_t q;
        q = '{px, py, pz, sx, sy, sz, ex, ey, ez};
        return q;
    endfunction

    function automatic logic signed [CW-1:0] rand_coord();
        return $urandom();
    endfunction

    // small box around the origin so all three regions show up often
    function automatic logic signed [CW-1:0] rand_near(int span);
        return $signed($urandom_range(2 * span, 0)) - span;
    endfunction

    // One beat: hold start and the payload until an edge with busy low.
    // Burst/gap shaping lives here so every test gets the same idling.
    task automatic send_query(query_t q);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(40, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        query <= q;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_dist.push_back(predict_distance(q));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (expected_dist.size() != 0)
            @(posedge clk);
    endtask

    // Directed: extremes, zero edge, endpoints, interior, largest distances.
    task automatic test_directed();
        send_query(mk_query(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_query(mk_query(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        send_query(mk_query(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
        // zero-length edge far from the point: endpoint branch, largest distance
        send_query(mk_query(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
        send_query(mk_query(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX));
        // longest edge, point in the middle of it
        send_query(mk_query(0, 0, 0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
        send_query(mk_query(CMAX, CMIN, 0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
        send_query(mk_query(CMIN, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX));
        // interior, height 5
        send_query(mk_query(5 * ONE, 3 * ONE, 4 * ONE, 0, 0, 0, 10 * ONE, 0, 0));
        // behind start, past end
        send_query(mk_query(-3 * ONE, 4 * ONE, 0, 0, 0, 0, 10 * ONE, 0, 0));
        send_query(mk_query(13 * ONE, 0, 4 * ONE, 0, 0, 0, 10 * ONE, 0, 0));
        // point on each endpoint, and on the segment
        send_query(mk_query(ONE, ONE, ONE, ONE, ONE, ONE, 2 * ONE, 3 * ONE, ONE));
        send_query(mk_query(2 * ONE, 3 * ONE, ONE, ONE, ONE, ONE, 2 * ONE, 3 * ONE, ONE));
        send_query(mk_query(ONE, ONE, ONE, 0, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE));
        // zero edge with nearby point, and one-LSB coordinates
        send_query(mk_query(ONE, 2 * ONE, -ONE, 7, 7, 7, 7, 7, 7));
        send_query(mk_query(1, 0, 0, 0, 0, 0, 0, 1, 0));
        send_query(mk_query(-1, -1, -1, 1, 1, 1, -2, 3, -4));
        send_query(mk_query(0, 0, CMAX, 0, 0, CMIN, 0, 0, 0));
        send_query(mk_query(CMAX, 0, 0, CMIN, 0, 0, CMIN, 1, 0));
    endtask

    task automatic test_random_full(int n);
        for (int i = 0; i < n; i++)
            send_query(mk_query(rand_coord(), rand_coord(), rand_coord(),
                                rand_coord(), rand_coord(), rand_coord(),
                                rand_coord(), rand_coord(), rand_coord()));
    endtask

    task automatic test_random_local(int n);
        int span;
        logic signed [CW-1:0] sx, sy, sz;
        for (int i = 0; i < n; i++)
        begin
            span = ($urandom_range(1, 0) == 0) ? 16 : 40 * 65536;
            sx = rand_near(span);
            sy = rand_near(span);
            sz = rand_near(span);
            // some beats reuse the start as end: zero-length edge
            if ($urandom_range(15, 0) == 0)
                send_query(mk_query(rand_near(span), rand_near(span), rand_near(span),
                                    sx, sy, sz, sx, sy, sz));
            else
                send_query(mk_query(rand_near(span), rand_near(span), rand_near(span),
                                    sx, sy, sz,
                                    rand_near(span), rand_near(span), rand_near(span)));
        end
    endtask

    // done is registered in the block, so the edge sample is the old value
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_dist.size() == 0)
            begin
                $display("%0t: unexpected result dist=%0d region=%0d",
                         $time, result.dist_res, result.region);
                fails++;
            end
            else
            begin
                result_t want;
                want = expected_dist.pop_front();
                if (want.dist_res !== result.dist_res)
                begin
                    $display("%0t: dist_res expected %0d actual %0d",
                             $time, want.dist_res, result.dist_res);
                    fails++;
                end
                if (want.region !== result.region)
                begin
                    $display("%0t: region expected %0d actual %0d",
                             $time, want.region, result.region);
                    fails++;
                end
            end
        end
    end

    // watchdog: any accepted beat or result resets the count
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        burst_left = 0;
        rst_n = 1'b0;
        start = 1'b0;
        query = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        drain_results();           // sender holds off until the pipe is empty
        test_random_full(600);
        test_random_local(1050);
        drain_results();
        repeat (LATENCY + 20) @(posedge clk);

        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

### filelist.f
design/psd3_pkg.sv
design/point_segment_distance_3d.sv
design/psd3_checker.sv
bench/tb_top.sv
